>>> rtl/core/graph_adjacency_query_core_macros.svh
// ----------------------------------------------------------------------------
// graph adjacency query core assertion macros
// shared concurrent assertion forms, synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef GRAPH_ADJACENCY_QUERY_CORE_MACROS_SVH
`define GRAPH_ADJACENCY_QUERY_CORE_MACROS_SVH

// same-cycle implication
`define GAQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gaq assertion failed");

// next-cycle implication
`define GAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gaq assertion failed");

`endif

>>> rtl/core/gaq_pkg.sv
// ----------------------------------------------------------------------------
// gaq_pkg
// shared types and codes of the graph adjacency query core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gaq_pkg;

  localparam int TOTAL_W = 21;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 21'h1FFFFF;

  // item functions
  localparam logic [1:0] FUNC_SET   = 2'd0;
  localparam logic [1:0] FUNC_EDGE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NEIGHBOR = 2'd0;
  localparam logic [1:0] KIND_TOTAL    = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd2;
  localparam logic [1:0] KIND_REJECT   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  slot;
    logic [7:0]  key;
    logic [7:0]  neighbor;
    logic [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         symbol;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic set_id;
    logic scan;
    logic ins_rd;
    logic ins_shift;
    logic ins_new;
    logic q_rd;
    logic q_emit;
    logic q_tot;
    logic msg_emit;
  } gaq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       hit;
    logic       miss;
    logic       deg_full;
    logic       deg_zero;
    logic       j_zero;
    logic       greater;
    logic       q_done;
    logic       out_free;
  } gaq_status_t;

endpackage

>>> rtl/core/gaq_ram.sv
// ----------------------------------------------------------------------------
// gaq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/gaq_ctrl.sv
// ----------------------------------------------------------------------------
// gaq_ctrl
// sequencing state machine for slot search, sorted insert and query replay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaq_ctrl
  import gaq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  output logic        in_stall,
  input  gaq_status_t status,
  output gaq_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_MSG     = 4'd3;
  localparam logic [3:0] S_INS_CHK = 4'd4;
  localparam logic [3:0] S_INS_CMP = 4'd5;
  localparam logic [3:0] S_QRD     = 4'd6;
  localparam logic [3:0] S_QEMIT   = 4'd7;
  localparam logic [3:0] S_QTOT    = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_func)
            FUNC_SET:   cmd.set_id = 1'b1;
            FUNC_EDGE:  state_nxt = S_FIND;
            FUNC_QUERY: state_nxt = S_FIND;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          state_nxt = S_DISP;
        end else if (status.miss) begin
          state_nxt = S_MSG;
        end
      end
      S_DISP: begin
        if (status.func == FUNC_EDGE) begin
          state_nxt = status.deg_full ? S_MSG : S_INS_CHK;
        end else begin
          state_nxt = status.deg_zero ? S_QTOT : S_QRD;
        end
      end
      S_MSG: begin
        if (status.out_free) begin
          cmd.msg_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_INS_CHK: begin
        if (status.j_zero) begin
          cmd.ins_new = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.greater) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_CHK;
        end else begin
          cmd.ins_new = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_QRD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = S_QEMIT;
      end
      S_QEMIT: begin
        if (status.out_free) begin
          cmd.q_emit = 1'b1;
          state_nxt  = status.q_done ? S_QTOT : S_QRD;
        end
      end
      S_QTOT: begin
        if (status.out_free) begin
          cmd.q_tot = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/gaq_dpath.sv
// ----------------------------------------------------------------------------
// gaq_dpath
// slot table, degree table, edge stores, search, insert and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaq_dpath
  import gaq_pkg::*;
#(
  parameter int VERTEX_SLOTS = 26,
  parameter int MAX_DEGREE   = 26,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  output logic        out_valid,
  input  logic        out_stall,
  input  gaq_cmd_t    cmd,
  output gaq_status_t status
);

  localparam int SLOT_W  = $clog2(VERTEX_SLOTS);
  localparam int CNT_W   = ($clog2(VERTEX_SLOTS + 1) > 5) ? $clog2(VERTEX_SLOTS + 1) : 5;
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int ST_DEP  = VERTEX_SLOTS * MAX_DEGREE;
  localparam int ST_AW   = $clog2(ST_DEP);
  localparam int SUM_W   = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;

  logic [4:0]              vcount_r, vcount_nxt;
  in_item_t                item_r, item_nxt;
  logic [CNT_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                    cmp_valid_r, cmp_valid_nxt;
  logic [SLOT_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                    id_ok_r, id_ok_nxt;
  logic                    deg_ok_r, deg_ok_nxt;
  logic [SLOT_W-1:0]       s_r, s_nxt;
  logic [DEG_W-1:0]        deg_r, deg_nxt;
  logic [ST_AW-1:0]        base_r, base_nxt;
  logic [DEG_W-1:0]        j_r, j_nxt;
  logic [DEG_W-1:0]        k_r, k_nxt;
  logic [TOTAL_W-1:0]      sum_r, sum_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VERTEX_SLOTS-1:0] id_vld_r, id_vld_nxt;
  logic [VERTEX_SLOTS-1:0] deg_vld_r, deg_vld_nxt;

  logic [CNT_W-1:0]        limit;
  logic [CNT_W-1:0]        slot_in;
  logic                    set_ok;
  logic                    scan_issue;
  logic [7:0]              id_rd;
  logic [DEG_W-1:0]        deg_rd;
  logic [7:0]              id_eff;
  logic [DEG_W-1:0]        deg_eff;
  logic                    hit;
  logic [7:0]              nb_rd;
  logic [WEIGHT_BITS-1:0]  wt_rd;
  logic [WEIGHT_BITS+15:0] w_wide;
  logic [WEIGHT_BITS-1:0]  w_in;
  logic [SUM_W-1:0]        sum_wide;
  logic                    out_free;
  logic                    load;

  logic                    id_we;
  logic                    deg_we;
  logic [DEG_W-1:0]        deg_wdata;
  logic                    st_we;
  logic [ST_AW-1:0]        st_waddr;
  logic [7:0]              st_wnb;
  logic [WEIGHT_BITS-1:0]  st_wwt;
  logic                    st_re;
  logic [ST_AW-1:0]        st_raddr;

  // effective slot count, clamped to the table size
  assign limit = (CNT_W'(vcount_r) > CNT_W'(VERTEX_SLOTS)) ? CNT_W'(VERTEX_SLOTS)
                                                          : CNT_W'(vcount_r);

  assign slot_in = CNT_W'(in_data.slot);
  assign set_ok  = (slot_in < CNT_W'(VERTEX_SLOTS));

  assign id_eff  = id_ok_r ? id_rd : 8'd0;
  assign deg_eff = deg_ok_r ? deg_rd : '0;
  assign hit     = cmp_valid_r && (id_eff == item_r.key);

  assign scan_issue = cmd.scan && !hit && (scan_cnt_r < limit);

  assign w_wide = {{WEIGHT_BITS{1'b0}}, item_r.weight};
  assign out_free = !out_valid_r || !out_stall;
  assign load     = cmd.msg_emit || cmd.q_emit || cmd.q_tot;

  assign sum_wide = SUM_W'(sum_r) + SUM_W'(wt_rd);

  // table writes
  assign id_we     = cmd.set_id && set_ok;
  assign deg_we    = cmd.ins_new;
  assign deg_wdata = deg_r + DEG_W'(1);

  // edge store ports
  assign st_we    = cmd.ins_shift || cmd.ins_new;
  assign st_waddr = base_r + ST_AW'(j_r);
  assign st_wnb   = cmd.ins_shift ? nb_rd : item_r.neighbor;
  assign st_wwt   = cmd.ins_shift ? wt_rd : w_in;
  assign st_re    = cmd.ins_rd || cmd.q_rd;
  assign st_raddr = cmd.q_rd ? (base_r + ST_AW'(k_r)) : (base_r + ST_AW'(j_r) - ST_AW'(1));

  gaq_ram #(.WIDTH(8), .DEPTH(VERTEX_SLOTS)) u_id_ram (
    .clk     (clk),
    .wr_en   (id_we),
    .wr_addr (slot_in[SLOT_W-1:0]),
    .wr_data (in_data.key),
    .rd_en   (scan_issue),
    .rd_addr (scan_cnt_r[SLOT_W-1:0]),
    .rd_data (id_rd)
  );

  gaq_ram #(.WIDTH(DEG_W), .DEPTH(VERTEX_SLOTS)) u_deg_ram (
    .clk     (clk),
    .wr_en   (deg_we),
    .wr_addr (s_r),
    .wr_data (deg_wdata),
    .rd_en   (scan_issue),
    .rd_addr (scan_cnt_r[SLOT_W-1:0]),
    .rd_data (deg_rd)
  );

  gaq_ram #(.WIDTH(8), .DEPTH(ST_DEP)) u_nb_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wnb),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (nb_rd)
  );

  gaq_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ST_DEP)) u_wt_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wwt),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (wt_rd)
  );

  always_comb begin
    w_in          = w_wide[WEIGHT_BITS-1:0];
    vcount_nxt    = cfg_we ? cfg_wdata : vcount_r;
    item_nxt      = cmd.accept ? in_data : item_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    id_ok_nxt     = id_ok_r;
    deg_ok_nxt    = deg_ok_r;
    s_nxt         = s_r;
    deg_nxt       = deg_r;
    base_nxt      = base_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    id_vld_nxt    = id_vld_r;
    deg_vld_nxt   = deg_vld_r;

    if (cmd.accept) begin
      scan_cnt_nxt  = '0;
      cmp_valid_nxt = 1'b0;
    end
    if (id_we) begin
      id_vld_nxt[slot_in[SLOT_W-1:0]] = 1'b1;
    end

    // pipelined slot search, one compare per cycle
    if (cmd.scan) begin
      cmp_valid_nxt = scan_issue;
      if (scan_issue) begin
        cmp_idx_nxt  = scan_cnt_r[SLOT_W-1:0];
        id_ok_nxt    = id_vld_r[scan_cnt_r[SLOT_W-1:0]];
        deg_ok_nxt   = deg_vld_r[scan_cnt_r[SLOT_W-1:0]];
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
      end
      if (hit) begin
        s_nxt    = cmp_idx_r;
        deg_nxt  = deg_eff;
        base_nxt = ST_AW'(ST_AW'(cmp_idx_r) * ST_AW'(MAX_DEGREE));
        j_nxt    = deg_eff;
        k_nxt    = '0;
        sum_nxt  = '0;
      end
    end

    if (cmd.ins_shift) begin
      j_nxt = j_r - DEG_W'(1);
    end
    if (cmd.ins_new) begin
      deg_vld_nxt[s_r] = 1'b1;
    end

    if (cmd.q_emit) begin
      k_nxt   = k_r + DEG_W'(1);
      sum_nxt = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    end
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt.total = '0;
      if (cmd.msg_emit) begin
        out_nxt.kind   = (item_r.func == FUNC_EDGE) ? KIND_REJECT : KIND_UNKNOWN;
        out_nxt.symbol = item_r.key;
        out_nxt.last   = 1'b1;
      end else if (cmd.q_emit) begin
        out_nxt.kind   = KIND_NEIGHBOR;
        out_nxt.symbol = nb_rd;
        out_nxt.last   = 1'b0;
      end else begin
        out_nxt.kind   = KIND_TOTAL;
        out_nxt.symbol = 8'd0;
        out_nxt.total  = sum_r;
        out_nxt.last   = 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      id_vld_r    <= '0;
      deg_vld_r   <= '0;
    end else begin
      vcount_r    <= vcount_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      id_vld_r    <= id_vld_nxt;
      deg_vld_r   <= deg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    id_ok_r    <= id_ok_nxt;
    deg_ok_r   <= deg_ok_nxt;
    s_r        <= s_nxt;
    deg_r      <= deg_nxt;
    base_r     <= base_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    sum_r      <= sum_nxt;
    out_r      <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_comb begin
    status          = '0;
    status.func     = item_r.func;
    status.hit      = hit;
    status.miss     = !cmp_valid_r && (scan_cnt_r >= limit);
    status.deg_full = (deg_r >= DEG_W'(MAX_DEGREE));
    status.deg_zero = (deg_r == '0);
    status.j_zero   = (j_r == '0);
    status.greater  = (nb_rd > item_r.neighbor);
    status.q_done   = ((DEG_W+1)'(k_r) + (DEG_W+1)'(1)) == (DEG_W+1)'(deg_r);
    status.out_free = out_free;
  end

endmodule

>>> rtl/core/graph_adjacency_query_core.sv
// ----------------------------------------------------------------------------
// graph_adjacency_query_core
// weighted directed adjacency table with sorted neighbor queries
// ----------------------------------------------------------------------------
// One transaction is taken at a time; in_stall stays high until the item's
// work is done. Set slot id and the unused func do not raise in_stall. Add
// edge and query first search the slot table one slot per cycle through its
// single registered read port, stopping at a match or, for a miss, after
// min(vertex_count, VERTEX_SLOTS) slots; a dispatch state then picks the
// branch. An added edge is then inserted in sorted place: each stored neighbor
// larger than the new one takes one store read and one store write to move
// up, then the new entry is written. A query replays the already sorted
// list, one store read and one result per neighbor, then the total; the
// consumer's out_stall holds the replay. Slot ids and degrees read as zero
// after reset through per-slot valid bits, so no clearing pass is needed;
// the edge stores are only read below a slot's degree.
`timescale 1ns / 1ps
`include "graph_adjacency_query_core_macros.svh"

module graph_adjacency_query_core
  import gaq_pkg::*;
#(
  parameter int VERTEX_SLOTS = 26,
  parameter int MAX_DEGREE   = 26,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  // item channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  // vertex_count register
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata
);

  gaq_cmd_t    cmd;
  gaq_status_t status;

  // controller: search, insert and replay sequencing
  gaq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: tables, edge stores kept sorted per slot, result register
  gaq_dpath #(
    .VERTEX_SLOTS (VERTEX_SLOTS),
    .MAX_DEGREE   (MAX_DEGREE),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // an edge or query transaction holds off the next item
  `GAQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall && ((in_data.func == FUNC_EDGE) || (in_data.func == FUNC_QUERY))), in_stall)

  // at most one store or result action per cycle
  `GAQ_ASSERT_IMPL(a_one_action, clk, rst_n, 1'b1, $onehot0({cmd.set_id, cmd.ins_shift, cmd.ins_new, cmd.q_emit, cmd.q_tot, cmd.msg_emit}))

  // the total closes the query's results
  `GAQ_ASSERT_NEXT(a_total_last, clk, rst_n, cmd.q_tot, (out_valid && out_data.last && (out_data.kind == KIND_TOTAL)))

  // results are only loaded into a free output register
  `GAQ_ASSERT_IMPL(a_load_free, clk, rst_n, (cmd.q_emit || cmd.q_tot || cmd.msg_emit), (!out_valid || !out_stall))

endmodule

>>> verif/graph_adjacency_query_core_checker.sv
// ----------------------------------------------------------------------------
// graph_adjacency_query_core_checker
// watches the item, result and register ports, keeps its own adjacency table
// and compares every accepted result against the predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_adjacency_query_core_checker
  import gaq_pkg::*;
#(
  parameter int VERTEX_SLOTS = 26,
  parameter int MAX_DEGREE   = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  output int         fail_count,
  output int         results_owed
);

  logic [4:0]  vertex_count;
  logic [7:0]  slot_ids [VERTEX_SLOTS];
  int          degree   [VERTEX_SLOTS];
  logic [7:0]  nbr_list [VERTEX_SLOTS][MAX_DEGREE];
  logic [15:0] wgt_list [VERTEX_SLOTS][MAX_DEGREE];
  out_item_t   reply_q[$];

  // first slot in use holding this id, or -1
  function automatic int lookup_slot(input logic [7:0] id);
    int limit;
    limit = (int'(vertex_count) > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(vertex_count);
    for (int i = 0; i < limit; i++)
      if (slot_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic out_item_t make_reply(input logic [1:0] kind, input logic [7:0] symbol,
                                           input logic [TOTAL_W-1:0] total, input logic last);
    out_item_t r;
    r.kind   = kind;
    r.symbol = symbol;
    r.total  = total;
    r.last   = last;
    return r;
  endfunction

  // update the table for one item and queue the replies it causes
  task automatic apply_graph_item(input in_item_t it);
    int          s;
    int          n;
    int          j;
    logic [7:0]  v;
    logic [7:0]  sorted [MAX_DEGREE];
    logic [31:0] sum;
    case (it.func)
      FUNC_SET: begin
        if (int'(it.slot) < VERTEX_SLOTS) slot_ids[it.slot] = it.key;
      end
      FUNC_EDGE: begin
        s = lookup_slot(it.key);
        if (s < 0 || degree[s] >= MAX_DEGREE) begin
          reply_q.push_back(make_reply(KIND_REJECT, it.key, '0, 1'b1));
        end else begin
          nbr_list[s][degree[s]] = it.neighbor;
          wgt_list[s][degree[s]] = it.weight;
          degree[s]++;
        end
      end
      FUNC_QUERY: begin
        s = lookup_slot(it.key);
        if (s < 0) begin
          reply_q.push_back(make_reply(KIND_UNKNOWN, it.key, '0, 1'b1));
        end else begin
          n   = degree[s];
          sum = '0;
          for (int i = 0; i < n; i++) begin
            v   = nbr_list[s][i];
            sum = sum + wgt_list[s][i];
            j   = i;
            while (j > 0 && sorted[j-1] > v) begin
              sorted[j] = sorted[j-1];
              j--;
            end
            sorted[j] = v;
          end
          for (int i = 0; i < n; i++)
            reply_q.push_back(make_reply(KIND_NEIGHBOR, sorted[i], '0, 1'b0));
          if (sum > TOTAL_MAX) sum = TOTAL_MAX;
          reply_q.push_back(make_reply(KIND_TOTAL, '0, sum[TOTAL_W-1:0], 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      vertex_count = '0;
      for (int i = 0; i < VERTEX_SLOTS; i++) begin
        slot_ids[i] = '0;
        degree[i]   = 0;
        for (int k = 0; k < MAX_DEGREE; k++) begin
          nbr_list[i][k] = '0;
          wgt_list[i][k] = '0;
        end
      end
      reply_q.delete();
    end else begin
      if (cfg_we) vertex_count = cfg_wdata;
      if (in_valid && !in_stall) apply_graph_item(in_data);
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d symbol %0h total %0d last %0b",
                   $time, out_data.kind, out_data.symbol, out_data.total, out_data.last);
          fail_count <= fail_count + 1;
        end else begin
          want = reply_q.pop_front();
          if (out_data.kind !== want.kind || out_data.symbol !== want.symbol ||
              out_data.total !== want.total || out_data.last !== want.last) begin
            $display("%0t: expected kind %0d symbol %0h total %0d last %0b", $time,
                     want.kind, want.symbol, want.total, want.last);
            $display("%0t: actual   kind %0d symbol %0h total %0d last %0b", $time,
                     out_data.kind, out_data.symbol, out_data.total, out_data.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    results_owed <= reply_q.size();
  end

endmodule

>>> verif/graph_adjacency_query_core_tb.sv
// ----------------------------------------------------------------------------
// graph_adjacency_query_core_tb
// drives directed and random set/edge/query traffic into the adjacency core
// under several idle and stall mixes; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_adjacency_query_core_tb;
  import gaq_pkg::*;

  localparam int SLOTS            = 26;
  localparam int DEGREE           = 26;
  // longest item without a result: slot search plus a full sorted insert
  localparam int SETTLE_CYCLES    = 120;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int LONG_HOLD        = 400;
  localparam int RUN_LIMIT_NS     = 4_000_000;
  // func code the core ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // ids that random traffic favors, so edges and queries mostly hit
  localparam logic [7:0] ID_POOL [10] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
                                          8'h05, 8'h06, 8'h11, 8'hAA, 8'hFF};

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int fail_count;
  int results_owed;
  int send_gap_pct = 0;  // chance in 100 that the sender idles a cycle
  int stall_pct    = 0;  // chance in 100 that the receiver stalls a cycle
  int hold_request = 0;  // each bump asks the receiver for one long hold

  graph_adjacency_query_core #(
    .VERTEX_SLOTS(SLOTS),
    .MAX_DEGREE  (DEGREE),
    .WEIGHT_BITS (16)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  graph_adjacency_query_core_checker #(
    .VERTEX_SLOTS(SLOTS),
    .MAX_DEGREE  (DEGREE)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case the core hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, or a long hold counted here when asked for
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // offer one transaction, idling first at random; valid stays high on return
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(input logic [1:0] func, input logic [4:0] slot,
                             input logic [7:0] key, input logic [7:0] nb,
                             input logic [15:0] w);
    in_item_t it;
    it.func     = func;
    it.slot     = slot;
    it.key      = key;
    it.neighbor = nb;
    it.weight   = w;
    send_item(it);
  endtask

  // stop offering, wait for every owed result, then let silent work finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only while the core is idle
  task automatic write_vertex_count(input logic [4:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_id();
    if ($urandom_range(99) < 75) return ID_POOL[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly edges and queries on known ids, some slot sets, a little noise
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    r = $urandom_range(99);
    if (r < 18)      it.func = FUNC_SET;
    else if (r < 58) it.func = FUNC_EDGE;
    else if (r < 95) it.func = FUNC_QUERY;
    else             it.func = FUNC_UNUSED;
    it.slot     = ($urandom_range(99) < 90) ? 5'($urandom_range(0, SLOTS - 1))
                                            : 5'($urandom_range(SLOTS, 31));
    it.key      = pick_id();
    it.neighbor = 8'($urandom_range(0, 255));
    r = $urandom_range(99);
    if (r < 10)      it.weight = 16'h0000;
    else if (r < 20) it.weight = 16'hFFFF;
    else             it.weight = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no slots in use: unknown query and unknown edge source
    send_fields(FUNC_QUERY, 5'd0, 8'h5A, 8'h00, 16'h0000);
    send_fields(FUNC_EDGE, 5'd0, 8'h00, 8'h12, 16'h1234);
    // ignored items: unused func and slot past the table
    send_fields(FUNC_UNUSED, 5'd3, 8'h01, 8'h01, 16'h0001);
    send_fields(FUNC_SET, 5'd31, 8'h77, 8'h00, 16'h0000);

    // register above the slot count acts as all slots
    write_vertex_count(5'd31);
    send_fields(FUNC_SET, 5'd0, 8'h11, 8'h00, 16'h0000);
    send_fields(FUNC_SET, 5'd25, 8'hFF, 8'h00, 16'h0000);
    send_fields(FUNC_SET, 5'd1, 8'hAA, 8'h00, 16'h0000);
    // same id twice, the lower slot wins
    send_fields(FUNC_SET, 5'd2, 8'hAA, 8'h00, 16'h0000);
    // vertex with no edges gives a lone zero total
    send_fields(FUNC_QUERY, 5'd0, 8'hAA, 8'h00, 16'h0000);
    // extremes of neighbor and weight, plus a duplicate neighbor
    send_fields(FUNC_EDGE, 5'd0, 8'hFF, 8'hFF, 16'hFFFF);
    send_fields(FUNC_EDGE, 5'd0, 8'hFF, 8'h00, 16'h0000);
    send_fields(FUNC_EDGE, 5'd0, 8'hFF, 8'h80, 16'h0001);
    send_fields(FUNC_EDGE, 5'd0, 8'hFF, 8'h80, 16'h5555);
    send_fields(FUNC_QUERY, 5'd0, 8'hFF, 8'h00, 16'h0000);
    send_fields(FUNC_EDGE, 5'd0, 8'hAA, 8'h42, 16'hAAAA);
    send_fields(FUNC_QUERY, 5'd0, 8'hAA, 8'h00, 16'h0000);

    // fill one list in descending order, one more edge is rejected as full
    for (int i = 0; i <= DEGREE; i++)
      send_fields(FUNC_EDGE, 5'd0, 8'h11, 8'(250 - 9 * i), 16'hFFFF - 16'(i));
    send_fields(FUNC_QUERY, 5'd0, 8'h11, 8'h00, 16'h0000);

    // shrinking the register keeps the table but hides upper slots
    write_vertex_count(5'd1);
    send_fields(FUNC_QUERY, 5'd0, 8'h11, 8'h00, 16'h0000);
    send_fields(FUNC_QUERY, 5'd0, 8'hFF, 8'h00, 16'h0000);
    send_fields(FUNC_EDGE, 5'd0, 8'hAA, 8'h01, 16'h0101);
    write_vertex_count(5'd0);
    send_fields(FUNC_QUERY, 5'd0, 8'h11, 8'h00, 16'h0000);

    // random phases, each with its own register value and idle mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_vertex_count(5'd26);
          send_gap_pct = 0;
          stall_pct    <= 0;
          // long receiver hold while big queries keep coming
          hold_request <= hold_request + 1;
          repeat (3) send_fields(FUNC_QUERY, 5'd0, 8'h11, 8'h00, 16'h0000);
        end
        1: begin
          write_vertex_count(5'($urandom_range(2, SLOTS - 1)));
          send_gap_pct = 48;
          stall_pct    <= 0;
        end
        2: begin
          write_vertex_count(5'd13);
          send_gap_pct = 0;
          stall_pct    <= 48;
        end
        default: begin
          write_vertex_count(5'd29);
          send_gap_pct = 6;
          stall_pct    <= 6;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // sender pause until the core has drained
        if (p == 2 && n == RANDOM_PER_PHASE / 2) settle();
        send_item(random_item());
      end
    end

    settle();
    if (fail_count == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
